[rtl/core/csc_pkg.sv]
// ----------------------------------------------------------------------------
// csc_pkg
// Shared constants and types for the causal sequence convolver: tap count,
// field widths and the command bundle that drives the sample stores.
// ----------------------------------------------------------------------------
package csc_pkg;

   localparam int TAPS     = 512;
   localparam int ADDR_W   = $clog2(TAPS);
   localparam int IDX_W    = $clog2(TAPS + 1);
   localparam int SAMPLE_W = 16;
   localparam int PROD_W   = 2 * SAMPLE_W;
   localparam int CONV_W   = 41;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [CONV_W-1:0]   conv_type;
   typedef logic [ADDR_W-1:0]          addr_type;

   typedef struct packed {
      logic       kernel_wr;
      addr_type   kernel_waddr;
      logic       signal_wr;
      addr_type   signal_waddr;
      logic       rd_en;
      addr_type   kernel_raddr;
      addr_type   signal_raddr;
   } mem_cmd_type;

endpackage

[rtl/core/causal_sequence_convolver_core.sv]
// ----------------------------------------------------------------------------
// causal_sequence_convolver_core
// Truncated causal convolution of two streamed sequences, one shared
// multiply-accumulate stepping over the stored kernel and signal history.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  kernel_value, signal_value, start_req
//  rsp_      out        rsp_valid/rsp_stall  conv_value (7 fraction bits)
//
// an item with n terms (n = index + 1, at most TAPS) is summed by the single
// multiply-accumulate reading one tap per cycle, behind a registered read
// and a registered product
// a finished result waits in the output register while the next request runs
// reset clears sequencer, counters and valids; stores are not cleared
// ----------------------------------------------------------------------------
module causal_sequence_convolver_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  csc_pkg::sample_type req_kernel_value,
   input  csc_pkg::sample_type req_signal_value,
   input  logic                req_start_req,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output csc_pkg::conv_type   rsp_conv_value
);
   import csc_pkg::*;

   localparam logic [IDX_W-1:0] TAPS_IDX  = IDX_W'(TAPS);
   localparam addr_type         LAST_ADDR = ADDR_W'(TAPS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   addr_type         hp_ff, hp_in;
   addr_type         j_ff, j_in;
   addr_type         slot_ff, slot_in;
   addr_type         last_ff, last_in;
   logic             rsp_valid_ff, rsp_valid_in;
   conv_type         rsp_conv_ff, rsp_conv_in;

   logic             accept;
   logic [IDX_W-1:0] idx_eff;
   logic             kernel_live;
   logic             pipe_empty;
   logic             rsp_load;
   mem_cmd_type      mem_cmd;
   sample_type       kernel_rd;
   sample_type       signal_rd;
   logic             rd_valid;
   conv_type         acc;
   logic             mac_busy;

   assign accept      = req_valid && !req_stall;
   assign req_stall   = (state_ff != ST_IDLE);
   assign idx_eff     = req_start_req ? '0 : idx_ff;
   assign kernel_live = (idx_eff < TAPS_IDX);
   assign pipe_empty  = !rd_valid && !mac_busy;
   assign rsp_load    = (state_ff == ST_DRAIN) && pipe_empty
                        && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      mem_cmd.kernel_wr    = accept && kernel_live;
      mem_cmd.kernel_waddr = idx_eff[ADDR_W-1:0];
      mem_cmd.signal_wr    = accept;
      mem_cmd.signal_waddr = hp_ff;
      mem_cmd.rd_en        = (state_ff == ST_RUN);
      mem_cmd.kernel_raddr = j_ff;
      mem_cmd.signal_raddr = slot_ff;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      hp_in        = hp_ff;
      j_in         = j_ff;
      slot_in      = slot_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_conv_in  = rsp_conv_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               j_in     = '0;
               slot_in  = hp_ff;
               hp_in    = (hp_ff == LAST_ADDR) ? '0 : hp_ff + 1'b1;
               if (kernel_live) begin
                  last_in = idx_eff[ADDR_W-1:0];
                  idx_in  = idx_eff + 1'b1;
               end else begin
                  last_in = LAST_ADDR;
                  idx_in  = TAPS_IDX;
               end
            end
         end
         ST_RUN: begin
            j_in    = j_ff + 1'b1;
            slot_in = (slot_ff == '0) ? LAST_ADDR : slot_ff - 1'b1;
            if (j_ff == last_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rsp_load) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_conv_in  = acc;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         hp_ff        <= '0;
         j_ff         <= '0;
         slot_ff      <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         hp_ff        <= hp_in;
         j_ff         <= j_in;
         slot_ff      <= slot_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_conv_ff <= rsp_conv_in;
   end

   csc_mem u_mem (
      .clock        (clock),
      .reset        (reset),
      .cmd          (mem_cmd),
      .kernel_wdata (req_kernel_value),
      .signal_wdata (req_signal_value),
      .kernel_rdata (kernel_rd),
      .signal_rdata (signal_rd),
      .rd_valid     (rd_valid)
   );

   csc_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .clear    (accept),
      .op_valid (rd_valid),
      .op_a     (kernel_rd),
      .op_b     (signal_rd),
      .acc      (acc),
      .busy     (mac_busy)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_conv_value = rsp_conv_ff;

`ifndef SYNTH
   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RUN))
      else $error("accepted request did not start the tap walk");

   a_tap_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (j_ff <= last_ff))
      else $error("tap counter ran past the last term");

   a_index_saturates: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= TAPS_IDX)
      else $error("item index above tap count");

   a_load_when_drained: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rd_valid && !mac_busy && !mem_cmd.rd_en))
      else $error("result taken before accumulator drained");

   a_no_read_while_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> !mac_busy || ($past(rd_valid)))
      else $error("products in flight with no reads issued");
`endif

endmodule

[rtl/core/csc_mem.sv]
// ----------------------------------------------------------------------------
// csc_mem
// Kernel store and circular signal history, one write and one registered
// read port each.
// ----------------------------------------------------------------------------
module csc_mem (
   input  logic                 clock,
   input  logic                 reset,
   input  csc_pkg::mem_cmd_type cmd,
   input  csc_pkg::sample_type  kernel_wdata,
   input  csc_pkg::sample_type  signal_wdata,
   output csc_pkg::sample_type  kernel_rdata,
   output csc_pkg::sample_type  signal_rdata,
   output logic                 rd_valid
);
   import csc_pkg::*;

   sample_type kernel_mem [TAPS];
   sample_type signal_mem [TAPS];
   sample_type kernel_rd_ff;
   sample_type signal_rd_ff;
   logic       rd_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.kernel_wr) begin
         kernel_mem[cmd.kernel_waddr] <= kernel_wdata;
      end
      if (cmd.rd_en) begin
         kernel_rd_ff <= kernel_mem[cmd.kernel_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.signal_wr) begin
         signal_mem[cmd.signal_waddr] <= signal_wdata;
      end
      if (cmd.rd_en) begin
         signal_rd_ff <= signal_mem[cmd.signal_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.rd_en;
      end
   end

   assign kernel_rdata = kernel_rd_ff;
   assign signal_rdata = signal_rd_ff;
   assign rd_valid     = rd_valid_ff;

endmodule

[rtl/core/csc_mac.sv]
// ----------------------------------------------------------------------------
// csc_mac
// Shared multiply-accumulate: registered 16x16 product, then a 41-bit
// accumulator that wraps.
// ----------------------------------------------------------------------------
module csc_mac (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic                op_valid,
   input  csc_pkg::sample_type op_a,
   input  csc_pkg::sample_type op_b,
   output csc_pkg::conv_type   acc,
   output logic                busy
);
   import csc_pkg::*;

   logic signed [PROD_W-1:0] product_ff;
   logic                     prod_valid_ff;
   conv_type                 acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= op_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (op_valid) begin
         product_ff <= op_a * op_b;
      end
      if (clear) begin
         acc_ff <= '0;
      end else if (prod_valid_ff) begin
         acc_ff <= acc_ff + {{(CONV_W-PROD_W){product_ff[PROD_W-1]}}, product_ff};
      end
   end

   assign acc  = acc_ff;
   assign busy = prod_valid_ff;

endmodule
